>>> sv/ppi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg
// Types and constants shared by the keyboard parallel port modules.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] ADDR_PORT_A  = 2'd0;
   localparam logic [1:0] ADDR_PORT_B  = 2'd1;
   localparam logic [1:0] ADDR_PORT_C  = 2'd2;
   localparam logic [1:0] ADDR_CONTROL = 2'd3;

   // Control word bit positions.
   localparam int CW_C_LOWER_IN = 0;
   localparam int CW_B_IN       = 1;
   localparam int CW_C_UPPER_IN = 3;
   localparam int CW_A_IN       = 4;
   localparam int CW_MODE_SET   = 7;

   localparam logic [7:0] CONTROL_RESET = 8'h9B;

   typedef struct packed {
      logic       opcode;
      logic [1:0] reg_addr;
      logic [7:0] write_data;
      logic [5:0] key_columns;
      logic       alias_key_down;
      logic       shift_down;
      logic       ctrl_down;
      logic       alt_down;
      logic       timer_level;
      logic       sync_active;
      logic [7:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] key_row;
      logic [3:0] video_mode;
      logic [7:0] port_c_out;
      logic       speaker;
   } rsp_type;

   typedef struct packed {
      logic [7:0] control_word;
      logic [7:0] port_a_latch;
      logic [7:0] port_b_latch;
      logic [7:0] port_c_latch;
      logic [7:0] last_repeat;
      logic [3:0] forced_shift_count;
   } state_type;

endpackage

>>> sv/ppi_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_access
// Decodes one bus access against the port state and gives the next state
// and the result item.
// ----------------------------------------------------------------------------
module ppi_access #(
   parameter int KEY_COLUMNS_N    = 6,
   parameter int SHIFT_HOLD_READS = 10
) (
   input  ppi_pkg::req_type   req,
   input  ppi_pkg::state_type state,
   output ppi_pkg::state_type state_next,
   output ppi_pkg::rsp_type   rsp
);

   localparam logic [5:0] COL_MASK = 6'((7'd1 << KEY_COLUMNS_N) - 7'd1);
   localparam logic [3:0] HOLD_LOAD = 4'(SHIFT_HOLD_READS);

   always_comb begin
      ppi_pkg::state_type ns;
      logic [7:0] rd;
      logic [7:0] v;
      logic [2:0] bit_idx;
      logic       blocked;
      logic [3:0] cnt;
      logic [7:0] cw;

      ns      = state;
      rd      = 8'h00;
      cw      = state.control_word;
      v       = req.write_data;
      bit_idx = req.write_data[3:1];
      blocked = (cw[ppi_pkg::CW_C_LOWER_IN] && !bit_idx[2]) ||
                (cw[ppi_pkg::CW_C_UPPER_IN] && bit_idx[2]);
      cnt     = state.forced_shift_count;

      if (req.opcode == ppi_pkg::OP_WRITE) begin
         unique case (req.reg_addr)
            ppi_pkg::ADDR_PORT_A: begin
               if (!cw[ppi_pkg::CW_A_IN]) ns.port_a_latch = req.write_data;
            end
            ppi_pkg::ADDR_PORT_B: begin
               if (!cw[ppi_pkg::CW_B_IN]) ns.port_b_latch = req.write_data;
            end
            ppi_pkg::ADDR_PORT_C: begin
               // Halves set as input keep their old latch bits.
               if (cw[ppi_pkg::CW_C_LOWER_IN]) v[3:0] = state.port_c_latch[3:0];
               if (cw[ppi_pkg::CW_C_UPPER_IN]) v[7:4] = state.port_c_latch[7:4];
               ns.port_c_latch = v;
            end
            default: begin
               if (req.write_data[ppi_pkg::CW_MODE_SET]) begin
                  ns.control_word = req.write_data;
               end else if (!blocked) begin
                  ns.port_c_latch[bit_idx] = req.write_data[0];
               end
            end
         endcase
      end else begin
         unique case (req.reg_addr)
            ppi_pkg::ADDR_PORT_A: begin
               rd = cw[ppi_pkg::CW_A_IN] ? 8'hFF : state.port_a_latch;
            end
            ppi_pkg::ADDR_PORT_B: begin
               if (cw[ppi_pkg::CW_B_IN]) begin
                  rd = {~req.shift_down, ~req.ctrl_down, ~(req.key_columns & COL_MASK)};
                  if (req.alias_key_down) cnt = HOLD_LOAD;
                  // While the countdown runs, shift reads as held.
                  if (cnt != 4'd0) begin
                     cnt   = cnt - 4'd1;
                     rd[7] = 1'b0;
                  end
                  ns.forced_shift_count = cnt;
               end else begin
                  rd = state.port_b_latch;
               end
            end
            ppi_pkg::ADDR_PORT_C: begin
               rd[3:0] = cw[ppi_pkg::CW_C_LOWER_IN] ? 4'hF : state.port_c_latch[3:0];
               if (cw[ppi_pkg::CW_C_UPPER_IN]) begin
                  rd[4] = req.timer_level;
                  rd[5] = 1'b0;
                  rd[6] = (req.repeat_count == state.last_repeat) && !req.alt_down;
                  rd[7] = !req.sync_active;
                  ns.last_repeat = req.repeat_count;
               end else begin
                  rd[7:4] = state.port_c_latch[7:4];
               end
            end
            default: begin
               rd = cw;
            end
         endcase
      end

      state_next     = ns;
      rsp.read_data  = rd;
      rsp.key_row    = ns.port_a_latch[3:0];
      rsp.video_mode = ns.port_a_latch[7:4];
      rsp.port_c_out = ns.port_c_latch;
      rsp.speaker    = ns.port_c_latch[2];
   end

endmodule

>>> sv/ppi_8255_keyboard_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_8255_keyboard_port
// Mode-0 parallel port with keyboard scan, speaker and video mode latches.
// ----------------------------------------------------------------------------
// Each request item is one bus access to port A, B, C or the control word and
// produces exactly one response item. A request is captured in an input
// register and decoded in the following cycle; the decode updates the port
// state and loads the response register once that register is free or
// drains. One item is taken per cycle while the response side keeps up. The
// response register lets the next request enter while a finished response
// still waits.
module ppi_8255_keyboard_port #(
   parameter int KEY_COLUMNS_N    = 6,
   parameter int SHIFT_HOLD_READS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppi_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppi_pkg::rsp_type rsp
);

   ppi_pkg::req_type   in_ff, in_in;
   logic               in_valid_ff, in_valid_in;
   ppi_pkg::state_type state_ff, state_in, state_next;
   ppi_pkg::rsp_type   rsp_ff, rsp_in, rsp_calc;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               advance;

   ppi_access #(
      .KEY_COLUMNS_N   (KEY_COLUMNS_N),
      .SHIFT_HOLD_READS(SHIFT_HOLD_READS)
   ) u_access (
      .req       (in_ff),
      .state     (state_ff),
      .state_next(state_next),
      .rsp       (rsp_calc)
   );

   // The decoded item moves on when the response register is free or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (advance) begin
         state_in     = state_next;
         rsp_in       = rsp_calc;
         rsp_valid_in = 1'b1;
         in_valid_in  = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_in       = req;
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         state_ff.control_word       <= ppi_pkg::CONTROL_RESET;
         state_ff.port_a_latch       <= 8'h00;
         state_ff.port_b_latch       <= 8'h00;
         state_ff.port_c_latch       <= 8'h00;
         state_ff.last_repeat        <= 8'h00;
         state_ff.forced_shift_count <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // A decoded item always lands in the response register.
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded item did not reach the response register");

   // The forced-shift countdown never runs above its load value.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.forced_shift_count <= 4'(SHIFT_HOLD_READS))
      else $error("forced-shift countdown out of range");

   // A mode-set write loads the control word.
   a_mode_set: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.opcode == ppi_pkg::OP_WRITE &&
      in_ff.reg_addr == ppi_pkg::ADDR_CONTROL &&
      in_ff.write_data[ppi_pkg::CW_MODE_SET]
      |=> state_ff.control_word == $past(in_ff.write_data))
      else $error("mode-set write did not load the control word");

   // The output-side fields of a response match the latches after its access.
   a_rsp_latch: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp.port_c_out == state_ff.port_c_latch &&
                  rsp.key_row == state_ff.port_a_latch[3:0])
      else $error("response latch fields disagree with port state");

endmodule

>>> tb/tb_ppi_8255_keyboard_port.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppi_8255_keyboard_port
// Self-checking bench for the keyboard parallel port. A directed sequence
// walks the direction modes, the keyboard scan, the port C status bits and
// bit set/reset. A long random mix of bus accesses follows. Every response
// is compared with a behavioral model of the port kept inside the bench.
// ----------------------------------------------------------------------------
module tb_ppi_8255_keyboard_port;

   localparam int KEY_COLUMNS_N    = 6;
   localparam int SHIFT_HOLD_READS = 10;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int IDLE_LIMIT       = 2000;
   localparam int DRAIN_CYCLES     = 10;
   localparam int MAX_REPORTS      = 10;

   // Receiver stall behaviors.
   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;
   localparam int STALL_HEAVY   = 3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ppi_pkg::req_type req = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ppi_pkg::rsp_type rsp;

   ppi_8255_keyboard_port #(
      .KEY_COLUMNS_N   (KEY_COLUMNS_N),
      .SHIFT_HOLD_READS(SHIFT_HOLD_READS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state of the port.
   logic [7:0] ctrl_word;
   logic [7:0] latch_a;
   logic [7:0] latch_b;
   logic [7:0] latch_c;
   logic [7:0] last_rep;
   logic [3:0] shift_hold;

   ppi_pkg::req_type access_q[$];
   ppi_pkg::rsp_type expected_q[$];

   int mismatches = 0;
   int checked = 0;
   int n_reads = 0;
   int n_writes = 0;
   int mode_loads = 0;
   int forced_reads = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;

   function automatic ppi_pkg::rsp_type predict_access(ppi_pkg::req_type a);
      logic [7:0] rd;
      logic [7:0] v;
      logic [2:0] bit_idx;
      logic [5:0] col_mask;
      ppi_pkg::rsp_type r;
      rd = 8'h00;
      col_mask = 6'((1 << KEY_COLUMNS_N) - 1);
      if (a.opcode == ppi_pkg::OP_WRITE) begin
         case (a.reg_addr)
            ppi_pkg::ADDR_PORT_A: begin
               if (!ctrl_word[ppi_pkg::CW_A_IN]) latch_a = a.write_data;
            end
            ppi_pkg::ADDR_PORT_B: begin
               if (!ctrl_word[ppi_pkg::CW_B_IN]) latch_b = a.write_data;
            end
            ppi_pkg::ADDR_PORT_C: begin
               v = a.write_data;
               if (ctrl_word[ppi_pkg::CW_C_LOWER_IN]) v[3:0] = latch_c[3:0];
               if (ctrl_word[ppi_pkg::CW_C_UPPER_IN]) v[7:4] = latch_c[7:4];
               latch_c = v;
            end
            default: begin
               if (a.write_data[ppi_pkg::CW_MODE_SET]) begin
                  ctrl_word = a.write_data;
                  mode_loads++;
               end else begin
                  bit_idx = a.write_data[3:1];
                  // A bit that lies in an input half of port C is left alone.
                  if (!(ctrl_word[ppi_pkg::CW_C_LOWER_IN] && bit_idx < 3'd4) &&
                      !(ctrl_word[ppi_pkg::CW_C_UPPER_IN] && bit_idx > 3'd3))
                     latch_c[bit_idx] = a.write_data[0];
               end
            end
         endcase
      end else begin
         case (a.reg_addr)
            ppi_pkg::ADDR_PORT_A: rd = ctrl_word[ppi_pkg::CW_A_IN] ? 8'hFF : latch_a;
            ppi_pkg::ADDR_PORT_B: begin
               if (ctrl_word[ppi_pkg::CW_B_IN]) begin
                  rd = {~a.shift_down, ~a.ctrl_down, ~(a.key_columns & col_mask)};
                  if (a.alias_key_down) shift_hold = 4'(SHIFT_HOLD_READS);
                  if (shift_hold != 4'd0) begin
                     shift_hold = shift_hold - 4'd1;
                     rd[7] = 1'b0;
                     forced_reads++;
                  end
               end else begin
                  rd = latch_b;
               end
            end
            ppi_pkg::ADDR_PORT_C: begin
               rd[3:0] = ctrl_word[ppi_pkg::CW_C_LOWER_IN] ? 4'hF : latch_c[3:0];
               if (ctrl_word[ppi_pkg::CW_C_UPPER_IN]) begin
                  rd[4] = a.timer_level;
                  rd[5] = 1'b0;
                  rd[6] = (a.repeat_count == last_rep) && !a.alt_down;
                  rd[7] = !a.sync_active;
                  last_rep = a.repeat_count;
               end else begin
                  rd[7:4] = latch_c[7:4];
               end
            end
            default: rd = ctrl_word;
         endcase
      end
      r.read_data  = rd;
      r.key_row    = latch_a[3:0];
      r.video_mode = latch_a[7:4];
      r.port_c_out = latch_c;
      r.speaker    = latch_c[2];
      return r;
   endfunction

   function automatic ppi_pkg::req_type make_access(logic op, logic [1:0] addr,
                                                    logic [7:0] data);
      ppi_pkg::req_type a;
      a.opcode         = op;
      a.reg_addr       = addr;
      a.write_data     = data;
      a.key_columns    = 6'($urandom);
      a.alias_key_down = ($urandom_range(0, 9) == 0);
      a.shift_down     = 1'($urandom_range(0, 1));
      a.ctrl_down      = 1'($urandom_range(0, 1));
      a.alt_down       = ($urandom_range(0, 3) == 0);
      a.timer_level    = 1'($urandom_range(0, 1));
      a.sync_active    = 1'($urandom_range(0, 1));
      a.repeat_count   = 8'($urandom);
      return a;
   endfunction

   // Sender: bursts of back-to-back items separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   // Receiver: stall behavior changes mode every so often.
   int stall_mode = STALL_NONE;
   int mode_left = 0;
   int stall_step = 0;
   logic [7:0] stall_pattern = 8'hFF;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (access_q.size() != 0) begin
               req <= access_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_pattern = 8'($urandom);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left = mode_left - 1;
         end
         stall_step = stall_step + 1;
         case (stall_mode)
            STALL_NONE:    rsp_ready <= 1'b1;
            STALL_RANDOM:  rsp_ready <= 1'($urandom_range(0, 1));
            STALL_PATTERN: rsp_ready <= stall_pattern[stall_step % 8];
            default:       rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Checker: responses are compared before the item accepted at the same
   // edge adds its own expectation, since it cannot answer that early.
   always @(posedge clock) begin
      ppi_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: response with none expected: rsp=%h", rsp);
            end else begin
               want = expected_q.pop_front();
               if (rsp.read_data !== want.read_data || rsp.key_row !== want.key_row ||
                   rsp.video_mode !== want.video_mode ||
                   rsp.port_c_out !== want.port_c_out || rsp.speaker !== want.speaker) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"ERROR: response %0d (expected/actual): ",
                               "read_data %h/%h key_row %h/%h video_mode %h/%h ",
                               "port_c %h/%h speaker %b/%b"},
                              checked, want.read_data, rsp.read_data, want.key_row,
                              rsp.key_row, want.video_mode, rsp.video_mode,
                              want.port_c_out, rsp.port_c_out, want.speaker, rsp.speaker);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req.opcode == ppi_pkg::OP_WRITE) n_writes++;
            else n_reads++;
            expected_q.push_back(predict_access(req));
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else if (access_q.size() != 0 || req_valid || expected_q.size() != 0) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout: no handshake for %0d cycles, %0d responses outstanding",
                        IDLE_LIMIT, expected_q.size());
               $display("FAIL ppi_8255_keyboard_port");
               $finish;
            end
         end
      end
   end

   initial begin
      ppi_pkg::req_type item;
      int sel;
      logic [7:0] prev_rep;

      ctrl_word  = ppi_pkg::CONTROL_RESET;
      latch_a    = 8'h00;
      latch_b    = 8'h00;
      latch_c    = 8'h00;
      last_rep   = 8'h00;
      shift_hold = 4'd0;
      prev_rep   = 8'h00;

      // Directed part, starting from the reset mode where every port is input.
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_CONTROL, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_A, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_A, 8'h55));
      // All columns pressed with both modifiers, and a key that forces shift.
      item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_B, 8'h00);
      item.key_columns = 6'h3F;
      item.shift_down = 1'b1;
      item.ctrl_down = 1'b1;
      item.alias_key_down = 1'b1;
      access_q.push_back(item);
      // Nothing pressed; the forced shift is still counting down.
      item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_B, 8'h00);
      item.key_columns = 6'h00;
      item.shift_down = 1'b0;
      item.ctrl_down = 1'b0;
      item.alias_key_down = 1'b0;
      access_q.push_back(item);
      // Repeat counter unchanged, sync low, timer high: status bits 4, 6 and 7 set.
      item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'h00);
      item.repeat_count = 8'h00;
      item.alt_down = 1'b0;
      item.sync_active = 1'b0;
      item.timer_level = 1'b1;
      access_q.push_back(item);
      // Same counter but the repeat key held clears the flag.
      item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'h00);
      item.repeat_count = 8'h00;
      item.alt_down = 1'b1;
      item.sync_active = 1'b1;
      item.timer_level = 1'b0;
      access_q.push_back(item);
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_C, 8'hFF));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h0F));
      // Every port becomes output.
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h80));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_A, 8'hFF));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_A, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_A, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_B, 8'hFF));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_B, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_B, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_PORT_C, 8'hA5));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'h00));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h05));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h0E));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'h00));
      // Both halves of port C as input, then a bit set that must be ignored.
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h89));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL, 8'h01));
      access_q.push_back(make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL,
                                     ppi_pkg::CONTROL_RESET));
      access_q.push_back(make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'h00));

      // Random part. The repeat counter mostly stays put so the unchanged
      // flag is seen often, and forced shift is rare enough to run out.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 5)
            item = make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL,
                               8'($urandom) | 8'h80);
         else if (sel < 15)
            item = make_access(ppi_pkg::OP_WRITE, ppi_pkg::ADDR_CONTROL,
                               8'($urandom) & 8'h7F);
         else if (sel < 30)
            item = make_access(ppi_pkg::OP_WRITE, 2'($urandom_range(0, 2)), 8'($urandom));
         else if (sel < 55)
            item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_B, 8'($urandom));
         else if (sel < 80)
            item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_C, 8'($urandom));
         else if (sel < 90)
            item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_PORT_A, 8'($urandom));
         else
            item = make_access(ppi_pkg::OP_READ, ppi_pkg::ADDR_CONTROL, 8'($urandom));
         if ($urandom_range(0, 2) != 0) item.repeat_count = prev_rep;
         prev_rep = item.repeat_count;
         access_q.push_back(item);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (access_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_q.size() != 0) begin
         mismatches += expected_q.size();
         $display("ERROR: %0d responses never arrived", expected_q.size());
      end
      $display("Ran %0d bus accesses: %0d reads and %0d writes, %0d control word loads.",
               n_reads + n_writes, n_reads, n_writes, mode_loads);
      $display("Keyboard reads under forced shift: %0d; responses checked: %0d.",
               forced_reads, checked);
      $display("Mismatches: %0d.", mismatches);
      if (mismatches == 0)
         $display("PASS ppi_8255_keyboard_port");
      else
         $display("FAIL ppi_8255_keyboard_port");
      $finish;
   end

endmodule
